// ----- rtl/tst_pkg.sv -----
package tst_pkg;

  // report kinds
  localparam logic [1:0] FN_BEGIN  = 2'd0;
  localparam logic [1:0] FN_MOVE   = 2'd1;
  localparam logic [1:0] FN_END    = 2'd2;
  localparam logic [1:0] FN_CANCEL = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_DUP     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_INV_SCALE_X = 2'd2;
  localparam logic [1:0] REG_INV_SCALE_Y = 2'd3;

  localparam int          POS_W          = 24;
  localparam int          DIFF_W         = POS_W + 1;
  localparam int          PROD_W         = 2 * DIFF_W;
  localparam int          SLOT_FW        = 5;
  localparam int          ID_W           = 32;
  localparam logic [23:0] INV_SCALE_RST  = 24'd65536;
  localparam int          MID_DEPTH      = 2;
  localparam int          OUT_DEPTH      = 2;

  // classified report between slot table and coordinate mapper
  typedef struct packed {
    logic [1:0]                status;
    logic [1:0]                kind;
    logic [SLOT_FW-1:0]        slot;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic                      batch;
  } mid_item_t;

  // finished result
  typedef struct packed {
    logic [1:0]               status;
    logic [1:0]               kind;
    logic [SLOT_FW-1:0]       slot;
    logic signed [POS_W-1:0]  design_x;
    logic signed [POS_W-1:0]  design_y;
    logic                     batch;
  } res_item_t;

  // round half up from Q.24 to Q.8 and clamp to the 24 bit range
  function automatic logic signed [POS_W-1:0] sat_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]   s;
    logic signed [PROD_W-16:0] r;
    logic signed [POS_W-1:0]  res;
    s = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(32768));
    r = $signed(s[PROD_W:16]);
    if (r > $signed((PROD_W-15)'(8388607))) begin
      res = 24'sh7FFFFF;
    end else if (r < -$signed((PROD_W-15)'(8388608))) begin
      res = 24'sh800000;
    end else begin
      res = r[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/touch_slot_tracker.sv -----
// touch_slot_tracker: keeps up to MAX_SLOTS touch contacts. Each request is one touch
// report (begin, move, end, cancel) and gives exactly one result, in order. A begin with
// a new id takes the lowest free slot (status 1 if none is free, 3 if the id is active);
// move, end and cancel look the id up (status 2 if unknown), end and cancel free the slot.
// A delivered result carries the slot and the position as (pos - origin) * inv_scale,
// rounded half up to Q16.8 and saturated; other results carry zero slot and position.
// One request is taken per clock while full is low; the slot table compares all ids and
// picks the free slot in the accepting cycle, and the coordinate mapper is one registered
// 25x24 multiply per axis followed by round and clamp. A result moves through the mid
// queue, the multiply register and the result queue to the result ports. Short queues
// sit between table and mapper and in front of the result ports; either side can stall.
// Configuration registers: index 0 origin_x, 1 origin_y, 2 inv_scale_x, 3 inv_scale_y;
// write them only while no request is in flight.
module touch_slot_tracker #(
  parameter int MAX_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic signed [31:0] touch_id,
  input  logic signed [23:0] x_pos,
  input  logic signed [23:0] y_pos,
  input  logic               batch_last,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic [1:0]         event_kind,
  output logic [4:0]         slot_index,
  output logic signed [23:0] design_x,
  output logic signed [23:0] design_y,
  output logic               batch_end,
  // configuration writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata
);

  import tst_pkg::*;

  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic [23:0]        inv_scale_x;
  logic [23:0]        inv_scale_y;

  mid_item_t mid_wr_item;
  mid_item_t mid_rd_item;
  logic      mid_push;
  logic      mid_pop;
  logic      mid_full;
  logic      mid_empty;

  res_item_t res_wr_item;
  res_item_t res_rd_item;
  logic      res_push;
  logic      res_full;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      inv_scale_x <= INV_SCALE_RST;
      inv_scale_y <= INV_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORIGIN_X:    origin_x    <= $signed(cfg_wdata);
        REG_ORIGIN_Y:    origin_y    <= $signed(cfg_wdata);
        REG_INV_SCALE_X: inv_scale_x <= cfg_wdata;
        REG_INV_SCALE_Y: inv_scale_y <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // slot table: lookup, allocation and release
  tst_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .func       (func),
    .touch_id   (touch_id),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .batch_last (batch_last),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .q_full     (mid_full),
    .q_push     (mid_push),
    .q_item     (mid_wr_item)
  );

  assign full = mid_full;

  // classified reports waiting for the mapper
  tst_queue #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_wr_item),
    .rd_en   (mid_pop),
    .rd_data (mid_rd_item),
    .empty   (mid_empty),
    .full    (mid_full)
  );

  // coordinate mapper
  tst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mid_empty   (mid_empty),
    .mid_item    (mid_rd_item),
    .mid_pop     (mid_pop),
    .inv_scale_x (inv_scale_x),
    .inv_scale_y (inv_scale_y),
    .out_full    (res_full),
    .out_push    (res_push),
    .out_item    (res_wr_item)
  );

  // finished results, oldest on the ports
  tst_queue #(
    .WIDTH ($bits(res_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr_item),
    .rd_en   (pop),
    .rd_data (res_rd_item),
    .empty   (empty),
    .full    (res_full)
  );

  assign status     = res_rd_item.status;
  assign event_kind = res_rd_item.kind;
  assign slot_index = res_rd_item.slot;
  assign design_x   = res_rd_item.design_x;
  assign design_y   = res_rd_item.design_y;
  assign batch_end  = res_rd_item.batch;

endmodule

// ----- rtl/tst_queue.sv -----
module tst_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign empty   = (count == '0);
  assign full    = (count == (AW+1)'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + 1'b1)
    else $error("queue count missed a write");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    empty |-> wr_ptr == rd_ptr)
    else $error("empty queue with pointers apart");

endmodule

// ----- rtl/tst_front.sv -----
module tst_front #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [1:0]                 func,
  input  logic signed [31:0]         touch_id,
  input  logic signed [23:0]         x_pos,
  input  logic signed [23:0]         y_pos,
  input  logic                       batch_last,
  input  logic signed [23:0]         origin_x,
  input  logic signed [23:0]         origin_y,
  input  logic                       q_full,
  output logic                       q_push,
  output tst_pkg::mid_item_t         q_item
);

  import tst_pkg::*;

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [MAX_SLOTS-1:0] slot_active;
  logic [ID_W-1:0]      slot_contact_id [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] hit;
  logic [MAX_SLOTS-1:0] free_vec;
  logic [MAX_SLOTS-1:0] free_1h;
  logic [SLOT_W-1:0]    hit_idx;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W-1:0]    sel_idx;
  logic                 any_hit;
  logic                 any_free;
  logic [1:0]           st;
  logic                 accept;
  logic                 do_alloc;
  logic                 do_release;

  // parallel id compare over all slots
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      hit[i] = slot_active[i] && (slot_contact_id[i] == touch_id);
    end
  end

  // lowest free slot as a one-hot
  assign free_vec = ~slot_active;
  assign free_1h  = free_vec & (~free_vec + MAX_SLOTS'(1));
  assign any_hit  = |hit;
  assign any_free = |free_vec;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | SLOT_W'(i);
      end
      if (free_1h[i]) begin
        free_idx = free_idx | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (func == FN_BEGIN) begin
      if (any_hit) begin
        st = ST_DUP;
      end else if (any_free) begin
        st = ST_OK;
      end else begin
        st = ST_FULL;
      end
      sel_idx = free_idx;
    end else begin
      st      = any_hit ? ST_OK : ST_UNKNOWN;
      sel_idx = hit_idx;
    end
  end

  assign accept     = push && !q_full;
  assign q_push     = accept;
  assign do_alloc   = accept && (func == FN_BEGIN) && (st == ST_OK);
  assign do_release = accept && (func == FN_END || func == FN_CANCEL) && (st == ST_OK);

  always_comb begin
    q_item.status = st;
    q_item.kind   = func;
    q_item.batch  = batch_last;
    if (st == ST_OK) begin
      q_item.slot = SLOT_FW'(sel_idx);
      q_item.dx   = $signed({x_pos[23], x_pos}) - $signed({origin_x[23], origin_x});
      q_item.dy   = $signed({y_pos[23], y_pos}) - $signed({origin_y[23], origin_y});
    end else begin
      // zero offset maps to zero design coordinates
      q_item.slot = '0;
      q_item.dx   = '0;
      q_item.dy   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else begin
      if (do_alloc) begin
        slot_active[sel_idx] <= 1'b1;
      end
      if (do_release) begin
        slot_active[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_alloc) begin
      slot_contact_id[sel_idx] <= touch_id;
    end
  end

  a_unique_id: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit))
    else $error("contact id held by more than one slot");

  a_alloc: assert property (@(posedge clk) disable iff (rst)
    do_alloc |=> slot_active[$past(sel_idx)])
    else $error("allocated slot not active");

  a_release: assert property (@(posedge clk) disable iff (rst)
    do_release |=> !slot_active[$past(sel_idx)])
    else $error("released slot still active");

endmodule

// ----- rtl/tst_back.sv -----
module tst_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               mid_empty,
  input  tst_pkg::mid_item_t mid_item,
  output logic               mid_pop,
  input  logic [23:0]        inv_scale_x,
  input  logic [23:0]        inv_scale_y,
  input  logic               out_full,
  output logic               out_push,
  output tst_pkg::res_item_t out_item
);

  import tst_pkg::*;

  logic                      v1;
  logic                      advance;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic [1:0]                st1;
  logic [1:0]                kind1;
  logic [SLOT_FW-1:0]        slot1;
  logic                      batch1;

  assign advance  = !v1 || !out_full;
  assign mid_pop  = advance && !mid_empty;
  assign out_push = v1 && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= !mid_empty;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (mid_pop) begin
      prod_x <= mid_item.dx * $signed({1'b0, inv_scale_x});
      prod_y <= mid_item.dy * $signed({1'b0, inv_scale_y});
      st1    <= mid_item.status;
      kind1  <= mid_item.kind;
      slot1  <= mid_item.slot;
      batch1 <= mid_item.batch;
    end
  end

  // round and clamp on the way into the result queue
  always_comb begin
    out_item.status   = st1;
    out_item.kind     = kind1;
    out_item.slot     = slot1;
    out_item.design_x = sat_round(prod_x);
    out_item.design_y = sat_round(prod_y);
    out_item.batch    = batch1;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && out_full |=> v1 && $stable(prod_x) && $stable(slot1))
    else $error("multiply stage changed while blocked");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import tst_pkg::*;

  localparam int SLOTS       = 8;
  localparam int POOL_N      = 12;     // ids in play, a bit more than the slots
  localparam int PHASE_ITEMS = 125;    // random requests per configuration
  localparam int LONG_HOLD   = 80;     // long result-side hold, in cycles
  localparam int LIMIT       = 400000; // cycle budget for the whole run

  // ---------------------------------------------------------------------------
  // scoreboard: own copy of the slot table and the mapping registers, a queue of
  // the results still owed by the block, and the comparison against them
  // ---------------------------------------------------------------------------
  class touch_scoreboard;
    logic [23:0] org_x, org_y, inv_x, inv_y;
    bit          busy[SLOTS];
    logic [31:0] owner[SLOTS];
    res_item_t   awaited_results[$];
    int          mismatches;

    function new();
      org_x = '0;
      org_y = '0;
      inv_x = INV_SCALE_RST;
      inv_y = INV_SCALE_RST;
      foreach (busy[i]) busy[i] = 1'b0;
      mismatches = 0;
    endfunction

    task log_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_ORIGIN_X:    org_x = val;
        REG_ORIGIN_Y:    org_y = val;
        REG_INV_SCALE_X: inv_x = val;
        REG_INV_SCALE_Y: inv_y = val;
        default: ;
      endcase
    endfunction

    // (pos - origin) * inv_scale, Q.24 down to Q.8 rounding half up, then clamp
    function logic signed [23:0] to_design(logic signed [23:0] pos, logic [23:0] org,
                                           logic [23:0] inv);
      longint d, p, r;
      d = longint'(pos) - longint'($signed(org));
      p = d * longint'({40'd0, inv});
      r = (p + 64'sd32768) >>> 16;
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      return r[23:0];
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // one accepted request: update the slot table and queue its result
    function void note_report(logic [1:0] fn, logic [31:0] id, logic signed [23:0] xp,
                              logic signed [23:0] yp, logic last);
      res_item_t res;
      int hit, open;
      hit  = -1;
      open = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (busy[i] && owner[i] == id && hit < 0) hit = i;
        if (!busy[i] && open < 0) open = i;
      end
      res = '0;
      res.kind  = fn;
      res.batch = last;
      if (fn == FN_BEGIN) begin
        if (hit >= 0) begin
          res.status = ST_DUP;
        end else if (open < 0) begin
          res.status = ST_FULL;
        end else begin
          busy[open]  = 1'b1;
          owner[open] = id;
          hit         = open;
          res.status  = ST_OK;
        end
      end else if (hit < 0) begin
        res.status = ST_UNKNOWN;
      end else begin
        res.status = ST_OK;
        if (fn == FN_END || fn == FN_CANCEL) busy[hit] = 1'b0;
      end
      if (res.status == ST_OK) begin
        res.slot     = SLOT_FW'(hit);
        res.design_x = to_design(xp, org_x, inv_x);
        res.design_y = to_design(yp, org_y, inv_y);
      end
      awaited_results.push_back(res);
    endfunction

    task check_result(res_item_t got);
      res_item_t want;
      if (awaited_results.size() == 0) begin
        log_mismatch($sformatf("result with no request outstanding, status %0d", got.status));
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        log_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.kind !== want.kind)
        log_mismatch($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
      if (got.slot !== want.slot)
        log_mismatch($sformatf("slot_index %0d, want %0d", got.slot, want.slot));
      if (got.design_x !== want.design_x)
        log_mismatch($sformatf("design_x %h, want %h", got.design_x, want.design_x));
      if (got.design_y !== want.design_y)
        log_mismatch($sformatf("design_y %h, want %h", got.design_y, want.design_y));
      if (got.batch !== want.batch)
        log_mismatch($sformatf("batch_end %0d, want %0d", got.batch, want.batch));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, dut hookup
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst;
  logic               push, full, empty, pop;
  logic [1:0]         func;
  logic signed [31:0] touch_id;
  logic signed [23:0] x_pos, y_pos;
  logic               batch_last;
  logic [1:0]         status, event_kind;
  logic [4:0]         slot_index;
  logic signed [23:0] design_x, design_y;
  logic               batch_end;
  logic               cfg_we;
  logic [1:0]         cfg_addr;
  logic [23:0]        cfg_wdata;

  touch_scoreboard sb;
  logic [31:0]     id_pool[POOL_N];
  bit              sender_steady;   // stretch of back-to-back requests
  bit              receiver_steady; // stretch of pops every cycle
  int              cycles;
  int              results_taken;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  touch_slot_tracker #(.MAX_SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .touch_id   (touch_id),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .batch_last (batch_last),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .event_kind (event_kind),
    .slot_index (slot_index),
    .design_x   (design_x),
    .design_y   (design_y),
    .batch_end  (batch_end),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // mostly no gap or a short one, now and then a long one
  function automatic int idle_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // positions: full range, near the viewport origin, the extremes, zero
  function automatic logic [23:0] rand_pos(logic [23:0] org);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 24'($urandom());
    if (r < 85) return org + 24'($urandom_range(0, 8191)) - 24'd4096;
    if (r < 95) return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    return 24'h000000;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: called at a falling edge, returns at the falling edge after
  // the request went in; push stays high when the next one follows at once
  // ---------------------------------------------------------------------------
  task automatic send_report(logic [1:0] fn, logic [31:0] id, logic [23:0] xp,
                             logic [23:0] yp, logic last);
    int gap;
    gap = idle_len(sender_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       <= 1'b1;
    func       <= fn;
    touch_id   <= id;
    x_pos      <= xp;
    y_pos      <= yp;
    batch_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_report(fn, id, xp, yp, last);
    @(negedge clk);
  endtask

  // stop offering and wait until the block has handed back everything
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic set_config(logic [23:0] ox, logic [23:0] oy, logic [23:0] sx,
                            logic [23:0] sy);
    wait_drained();
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_INV_SCALE_X, sx);
    cfg_write(REG_INV_SCALE_Y, sy);
    cfg_we <= 1'b0;
  endtask

  // random traffic: mostly ids from a small pool so contacts really begin, move
  // and end, the table fills up and duplicates happen; some stray ids as noise
  task automatic send_random(int n, bit pause_midway);
    logic [1:0]  fn;
    logic [31:0] id;
    int          r;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      if (pause_midway && k == n / 2) wait_drained();
      if ($urandom_range(0, 99) < 3) id_pool[$urandom_range(0, POOL_N - 1)] = $urandom();
      r = $urandom_range(0, 99);
      if (r < 35)      fn = FN_BEGIN;
      else if (r < 70) fn = FN_MOVE;
      else if (r < 85) fn = FN_END;
      else             fn = FN_CANCEL;
      id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, POOL_N - 1)];
      send_report(fn, id, rand_pos(sb.org_x), rand_pos(sb.org_y),
                  ($urandom_range(0, 3) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    func       = FN_BEGIN;
    touch_id   = '0;
    x_pos      = '0;
    y_pos      = '0;
    batch_last = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_ORIGIN_X;
    cfg_wdata  = '0;
    sender_steady = 1'b0;
    sb = new();
    // pool starts with the id extremes
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_N; i++) id_pool[i] = $urandom();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset mapping (identity)
    // fill every slot, position extremes pass through unchanged
    send_report(FN_BEGIN, 32'h8000_0000, 24'h800000, 24'h7FFFFF, 1'b0);
    send_report(FN_BEGIN, 32'h7FFF_FFFF, 24'h7FFFFF, 24'h800000, 1'b1);
    send_report(FN_BEGIN, 32'h0000_0000, 24'h000000, 24'hFFFFFF, 1'b0);
    send_report(FN_BEGIN, 32'hFFFF_FFFF, 24'h555555, 24'hAAAAAA, 1'b0);
    send_report(FN_BEGIN, 32'h0000_0001, 24'hAAAAAA, 24'h555555, 1'b1);
    send_report(FN_BEGIN, 32'h5555_5555, 24'h000100, 24'hFFFF00, 1'b0);
    send_report(FN_BEGIN, 32'hAAAA_AAAA, 24'h123456, 24'h654321, 1'b0);
    send_report(FN_BEGIN, 32'h1234_5678, 24'h000001, 24'h000001, 1'b1);
    // table full, then a begin for an id already held
    send_report(FN_BEGIN, 32'h0F0F_0F0F, 24'h000010, 24'h000020, 1'b0);
    send_report(FN_BEGIN, 32'h0000_0000, 24'h000010, 24'h000020, 1'b1);
    // move of a held id, move of an id nobody holds
    send_report(FN_MOVE, 32'h7FFF_FFFF, 24'h000000, 24'h000000, 1'b0);
    send_report(FN_MOVE, 32'hDEAD_BEEF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    // end and cancel free slots, the next begin takes the lowest free one
    send_report(FN_END, 32'h0000_0000, 24'h800000, 24'h800000, 1'b0);
    send_report(FN_CANCEL, 32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000, 1'b1);
    send_report(FN_BEGIN, 32'h0F0F_0F0F, 24'h00FF00, 24'hFF00FF, 1'b0);
    // freed id is unknown again for end and cancel
    send_report(FN_END, 32'h0000_0000, 24'h000000, 24'h000000, 1'b0);
    send_report(FN_CANCEL, 32'h0000_0000, 24'h000000, 24'h000000, 1'b1);
    send_report(FN_MOVE, 32'h8000_0000, 24'h3C0000, 24'hC40000, 1'b0);
    send_report(FN_END, 32'h0F0F_0F0F, 24'h000000, 24'h7FFFFF, 1'b1);
    send_random(PHASE_ITEMS, 1'b0);

    // small offsets, half scale on y
    set_config(24'h000100, 24'hFFFF00, 24'd65536, 24'd32768);
    send_random(PHASE_ITEMS, 1'b0);
    // extreme origins, largest and smallest scale: heavy saturation on x
    set_config(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000001);
    send_random(PHASE_ITEMS, 1'b1);
    // everything random
    set_config(24'($urandom()), 24'($urandom()), 24'($urandom_range(1, 24'hFFFFFF)),
               24'($urandom_range(1, 24'hFFFFFF)));
    send_random(PHASE_ITEMS, 1'b0);
    // zero scale maps every position to zero
    set_config(24'($urandom()), 24'($urandom()), 24'h000000, 24'h000000);
    send_random(PHASE_ITEMS, 1'b0);
    // opposite origin extremes, modest scales
    set_config(24'h7FFFFF, 24'h800000, 24'($urandom_range(1, 24'h030000)),
               24'($urandom_range(1, 24'h030000)));
    send_random(PHASE_ITEMS, 1'b0);

    wait_drained();
    // keep clocking so any stray result is still caught
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random pops, two long holds so the block backs up into full
  // ---------------------------------------------------------------------------
  initial begin
    res_item_t got;
    int        gap;
    pop             = 1'b0;
    receiver_steady = 1'b0;
    results_taken   = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken % 50 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      if (results_taken == 200 || results_taken == 520) gap = LONG_HOLD;
      else gap = idle_len(receiver_steady);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.status   = status;
      got.kind     = event_kind;
      got.slot     = slot_index;
      got.design_x = design_x;
      got.design_y = design_y;
      got.batch    = batch_end;
      sb.check_result(got);
      results_taken++;
      @(negedge clk);
    end
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
